@@ rtl/core/v3a_pkg.sv @@
// ----------------------------------------------------------------------------
// v3a_pkg
// Shared constants, codes, types and the saturation helper of the vector unit.
// ----------------------------------------------------------------------------
package v3a_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WW        = 32;
  localparam int SW        = 66;
  localparam int NW        = WW + FRAC_BITS;
  localparam int FRONT_LAT = 4;
  localparam int SQ_STAGES = WW;
  localparam int SQ_LAT    = SQ_STAGES + 2;
  localparam int DIV_LAT   = NW + 1;
  localparam int LATENCY   = FRONT_LAT + SQ_LAT + DIV_LAT + 1;

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_SCALE = 3'd2;
  localparam logic [2:0] OP_DIV   = 3'd3;
  localparam logic [2:0] OP_DOT   = 3'd4;
  localparam logic [2:0] OP_CROSS = 3'd5;
  localparam logic [2:0] OP_LEN   = 3'd6;
  localparam logic [2:0] OP_NORM  = 3'd7;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  localparam logic [31:0] MAX_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] MIN_NEG = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] v;
    logic        s;
  } v3a_sat_t;

  typedef struct packed {
    logic [2:0]       op;
    logic [2:0][31:0] r_vec;
    logic [31:0]      r_scalar;
    logic             sat;
    logic [2:0][31:0] a_mag;
    logic [2:0]       a_neg;
    logic [31:0]      s_mag;
    logic             s_neg;
  } v3a_early_t;

  // sign/magnitude to saturated two's complement
  function automatic v3a_sat_t sat32(input logic neg, input logic [SW-1:0] m);
    v3a_sat_t r;
    r.s = 1'b0;
    r.v = '0;
    if (!neg) begin
      if (m > SW'(MAX_POS)) begin
        r.s = 1'b1;
        r.v = MAX_POS;
      end else begin
        r.v = m[31:0];
      end
    end else begin
      if (m > SW'(MIN_NEG)) begin
        r.s = 1'b1;
        r.v = MIN_NEG;
      end else begin
        r.v = ~m[31:0] + 32'd1;
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/core/v3a_front.sv @@
// ----------------------------------------------------------------------------
// v3a_front
// Four-stage front end: input register, products, sums, rescale with rounding.
// ----------------------------------------------------------------------------
module v3a_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [2:0]          op,
  input  logic signed [31:0]  a_x,
  input  logic signed [31:0]  a_y,
  input  logic signed [31:0]  a_z,
  input  logic signed [31:0]  b_x,
  input  logic signed [31:0]  b_y,
  input  logic signed [31:0]  b_z,
  input  logic signed [31:0]  scalar,
  output logic                out_valid,
  output v3a_pkg::v3a_early_t early,
  output logic [63:0]         sq
);

  logic                va, vb, vc;
  logic [2:0]          op_a;
  logic signed [31:0]  a_a [0:2];
  logic signed [31:0]  b_a [0:2];
  logic signed [31:0]  s_a;

  logic signed [31:0]  m_l [0:5];
  logic signed [31:0]  m_r [0:5];
  logic [32:0]         sum33 [0:2];
  v3a_pkg::v3a_early_t e_bn, e_b, e_c, e_dn;
  logic signed [63:0]  p_b [0:5];

  logic signed [65:0]  x [0:5];
  logic signed [65:0]  v_cn [0:2];
  logic signed [65:0]  v_c [0:2];
  logic [63:0]         sq_cn, sq_c;

  logic [65:0]         mg [0:2];
  logic [65:0]         rnd [0:2];
  v3a_pkg::v3a_sat_t   rs [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      va        <= in_valid;
      vb        <= va;
      vc        <= vb;
      out_valid <= vc;
    end
  end

  always_ff @(posedge clk) begin
    op_a   <= op;
    a_a[0] <= a_x;
    a_a[1] <= a_y;
    a_a[2] <= a_z;
    b_a[0] <= b_x;
    b_a[1] <= b_y;
    b_a[2] <= b_z;
    s_a    <= scalar;
  end

  // operand select and add/sub
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      m_l[k] = '0;
      m_r[k] = '0;
    end
    case (op_a)
      v3a_pkg::OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          m_l[i] = a_a[i];
          m_r[i] = s_a;
        end
      end
      v3a_pkg::OP_DOT: begin
        for (int i = 0; i < 3; i++) begin
          m_l[i] = a_a[i];
          m_r[i] = b_a[i];
        end
      end
      v3a_pkg::OP_CROSS: begin
        m_l[0] = a_a[1]; m_r[0] = b_a[2];
        m_l[1] = a_a[2]; m_r[1] = b_a[1];
        m_l[2] = a_a[2]; m_r[2] = b_a[0];
        m_l[3] = a_a[0]; m_r[3] = b_a[2];
        m_l[4] = a_a[0]; m_r[4] = b_a[1];
        m_l[5] = a_a[1]; m_r[5] = b_a[0];
      end
      v3a_pkg::OP_LEN, v3a_pkg::OP_NORM: begin
        for (int i = 0; i < 3; i++) begin
          m_l[i] = a_a[i];
          m_r[i] = a_a[i];
        end
      end
      default: begin
      end
    endcase

    e_bn       = '0;
    e_bn.op    = op_a;
    e_bn.s_neg = s_a[31];
    e_bn.s_mag = s_a[31] ? (~s_a + 32'sd1) : s_a;
    for (int i = 0; i < 3; i++) begin
      if (op_a == v3a_pkg::OP_SUB) begin
        sum33[i] = {a_a[i][31], a_a[i]} - {b_a[i][31], b_a[i]};
      end else begin
        sum33[i] = {a_a[i][31], a_a[i]} + {b_a[i][31], b_a[i]};
      end
      e_bn.a_neg[i] = a_a[i][31];
      e_bn.a_mag[i] = a_a[i][31] ? (~a_a[i] + 32'sd1) : a_a[i];
      if (op_a == v3a_pkg::OP_ADD || op_a == v3a_pkg::OP_SUB) begin
        if (sum33[i][32] != sum33[i][31]) begin
          e_bn.sat      = 1'b1;
          e_bn.r_vec[i] = sum33[i][32] ? v3a_pkg::MIN_NEG : v3a_pkg::MAX_POS;
        end else begin
          e_bn.r_vec[i] = sum33[i][31:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 6; k++) begin
      p_b[k] <= m_l[k] * m_r[k];
    end
    e_b <= e_bn;
  end

  // exact sums of products
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      x[k] = 66'(p_b[k]);
    end
    for (int i = 0; i < 3; i++) begin
      v_cn[i] = '0;
    end
    case (e_b.op)
      v3a_pkg::OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          v_cn[i] = x[i];
        end
      end
      v3a_pkg::OP_DOT: begin
        v_cn[0] = x[0] + x[1] + x[2];
      end
      v3a_pkg::OP_CROSS: begin
        v_cn[0] = x[0] - x[1];
        v_cn[1] = x[2] - x[3];
        v_cn[2] = x[4] - x[5];
      end
      default: begin
      end
    endcase
    sq_cn = 64'(p_b[0]) + 64'(p_b[1]) + 64'(p_b[2]);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      v_c[i] <= v_cn[i];
    end
    e_c  <= e_b;
    sq_c <= sq_cn;
  end

  // rescale, round half away from zero, saturate
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mg[i]  = v_c[i][65] ? (~v_c[i] + 66'sd1) : v_c[i];
      rnd[i] = (mg[i] >> v3a_pkg::FRAC_BITS) + 66'(mg[i][v3a_pkg::FRAC_BITS-1]);
      rs[i]  = v3a_pkg::sat32(v_c[i][65], rnd[i]);
    end
    e_dn = e_c;
    case (e_c.op)
      v3a_pkg::OP_SCALE, v3a_pkg::OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          e_dn.r_vec[i] = rs[i].v;
        end
        e_dn.sat = rs[0].s | rs[1].s | rs[2].s;
      end
      v3a_pkg::OP_DOT: begin
        e_dn.r_scalar = rs[0].v;
        e_dn.sat      = rs[0].s;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    early <= e_dn;
    sq    <= sq_c;
  end

endmodule

@@ rtl/core/v3a_sqrt.sv @@
// ----------------------------------------------------------------------------
// v3a_sqrt
// Pipelined integer square root, one root bit per stage, rounded to nearest.
// ----------------------------------------------------------------------------
module v3a_sqrt (
  input  logic        clk,
  input  logic [63:0] rad,
  output logic [31:0] root
);

  localparam int S = v3a_pkg::SQ_STAGES;

  logic [63:0] rad_q  [0:S];
  logic [33:0] rem_q  [0:S];
  logic [31:0] root_q [0:S];
  logic [33:0] rem_t  [0:S-1];
  logic [33:0] trial  [0:S-1];
  logic        ge     [0:S-1];

  always_comb begin
    for (int i = 0; i < S; i++) begin
      rem_t[i] = {rem_q[i][31:0], rad_q[i][63:62]};
      trial[i] = {root_q[i], 2'b01};
      ge[i]    = rem_t[i] >= trial[i];
    end
  end

  always_ff @(posedge clk) begin
    rad_q[0]  <= rad;
    rem_q[0]  <= '0;
    root_q[0] <= '0;
    for (int i = 0; i < S; i++) begin
      rad_q[i+1]  <= {rad_q[i][61:0], 2'b00};
      rem_q[i+1]  <= ge[i] ? (rem_t[i] - trial[i]) : rem_t[i];
      root_q[i+1] <= {root_q[i][30:0], ge[i]};
    end
    root <= root_q[S] + 32'(rem_q[S] > {2'b00, root_q[S]});
  end

endmodule

@@ rtl/core/v3a_div.sv @@
// ----------------------------------------------------------------------------
// v3a_div
// Three-lane pipelined restoring divider with a shared divisor, one quotient
// bit per stage; the numerator is biased by half the divisor for rounding.
// ----------------------------------------------------------------------------
module v3a_div (
  input  logic                             clk,
  input  logic [2:0][31:0]                 mag,
  input  logic [31:0]                      den,
  output logic [2:0][v3a_pkg::NW-1:0]      quo
);

  localparam int N = v3a_pkg::NW;

  logic [2:0][N-1:0] num_q [0:N];
  logic [2:0][32:0]  rem_q [0:N];
  logic [31:0]       den_q [0:N];
  logic [2:0][32:0]  rt    [0:N-1];
  logic [2:0]        ge    [0:N-1];

  always_comb begin
    for (int i = 0; i < N; i++) begin
      for (int l = 0; l < 3; l++) begin
        rt[i][l] = {rem_q[i][l][31:0], num_q[i][l][N-1]};
        ge[i][l] = rt[i][l] >= {1'b0, den_q[i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      num_q[0][l] <= (N'(mag[l]) << v3a_pkg::FRAC_BITS) + N'(den[31:1]);
      rem_q[0][l] <= '0;
    end
    den_q[0] <= den;
    for (int i = 0; i < N; i++) begin
      for (int l = 0; l < 3; l++) begin
        num_q[i+1][l] <= {num_q[i][l][N-2:0], ge[i][l]};
        rem_q[i+1][l] <= ge[i][l] ? (rt[i][l] - {1'b0, den_q[i]}) : rt[i][l];
      end
      den_q[i+1] <= den_q[i];
    end
  end

  assign quo = num_q[N];

endmodule

@@ rtl/core/vec3_arith_unit.sv @@
// ----------------------------------------------------------------------------
// vec3_arith_unit
// Q16.16 three-component vector unit: add, sub, scale, divide, dot, cross,
// length, normalize, with saturation and status.
//
// Usage: drive req_type, A, B and scalar with start high; the word is taken
// at that edge (busy is always low, so one word per cycle is accepted).
// Every word gives one result word, marked by done for exactly one cycle,
// in the order of acceptance. The word passes 88 register stages, the first
// loaded at the accepting edge: 4 front stages (register, multiply, sum,
// rescale), 34 square-root stages (one root bit per stage plus in/out
// registers), 49 divider stages (one quotient bit per stage for the 48-bit
// numerator plus an entry register) and one output register, which drives
// done and the result word.
// All opcodes take the same path so results never reorder. Throughput is
// one word per cycle. The receiver cannot stall; there is no back-pressure.
// Reset (rst, synchronous) drops all words in flight and clears done.
// ----------------------------------------------------------------------------
module vec3_arith_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         req_type,
  input  logic signed [31:0] a_x,
  input  logic signed [31:0] a_y,
  input  logic signed [31:0] a_z,
  input  logic signed [31:0] b_x,
  input  logic signed [31:0] b_y,
  input  logic signed [31:0] b_z,
  input  logic signed [31:0] scalar,
  output logic               done,
  output logic signed [31:0] r_x,
  output logic signed [31:0] r_y,
  output logic signed [31:0] r_z,
  output logic signed [31:0] r_scalar,
  output logic [1:0]         status
);

  localparam int SQL = v3a_pkg::SQ_LAT;
  localparam int DVL = v3a_pkg::DIV_LAT;

  logic                               f_valid;
  v3a_pkg::v3a_early_t                f_e;
  logic [63:0]                        f_sq;
  logic [31:0]                        len;

  logic                               d1_v [0:SQL-1];
  v3a_pkg::v3a_early_t                d1_e [0:SQL-1];
  logic                               d2_v [0:DVL-1];
  v3a_pkg::v3a_early_t                d2_e [0:DVL-1];
  logic [31:0]                        d2_len [0:DVL-1];

  v3a_pkg::v3a_early_t                e1, e2;
  logic [31:0]                        den, len2;
  logic [2:0][v3a_pkg::NW-1:0]        quo;

  logic [2:0][31:0]                   rv;
  logic [31:0]                        rsc;
  logic [1:0]                         st;
  v3a_pkg::v3a_sat_t                  qs [0:2];
  v3a_pkg::v3a_sat_t                  lq;

  assign busy = 1'b0;

  v3a_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .op        (req_type),
    .a_x       (a_x),
    .a_y       (a_y),
    .a_z       (a_z),
    .b_x       (b_x),
    .b_y       (b_y),
    .b_z       (b_z),
    .scalar    (scalar),
    .out_valid (f_valid),
    .early     (f_e),
    .sq        (f_sq)
  );

  v3a_sqrt u_sqrt (
    .clk  (clk),
    .rad  (f_sq),
    .root (len)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SQL; k++) begin
        d1_v[k] <= 1'b0;
      end
      for (int k = 0; k < DVL; k++) begin
        d2_v[k] <= 1'b0;
      end
    end else begin
      d1_v[0] <= f_valid;
      for (int k = 1; k < SQL; k++) begin
        d1_v[k] <= d1_v[k-1];
      end
      d2_v[0] <= d1_v[SQL-1];
      for (int k = 1; k < DVL; k++) begin
        d2_v[k] <= d2_v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    d1_e[0] <= f_e;
    for (int k = 1; k < SQL; k++) begin
      d1_e[k] <= d1_e[k-1];
    end
    d2_e[0]   <= e1;
    d2_len[0] <= len;
    for (int k = 1; k < DVL; k++) begin
      d2_e[k]   <= d2_e[k-1];
      d2_len[k] <= d2_len[k-1];
    end
  end

  assign e1   = d1_e[SQL-1];
  assign e2   = d2_e[DVL-1];
  assign len2 = d2_len[DVL-1];
  assign den  = (e1.op == v3a_pkg::OP_NORM) ? len : e1.s_mag;

  v3a_div u_div (
    .clk (clk),
    .mag (e1.a_mag),
    .den (den),
    .quo (quo)
  );

  always_comb begin
    rv  = e2.r_vec;
    rsc = e2.r_scalar;
    st  = e2.sat ? v3a_pkg::ST_SAT : v3a_pkg::ST_OK;
    lq  = v3a_pkg::sat32(1'b0, v3a_pkg::SW'(len2));
    for (int l = 0; l < 3; l++) begin
      qs[l] = v3a_pkg::sat32(
        (e2.op == v3a_pkg::OP_DIV) ? (e2.a_neg[l] ^ e2.s_neg) : e2.a_neg[l],
        v3a_pkg::SW'(quo[l]));
    end
    case (e2.op)
      v3a_pkg::OP_DIV: begin
        if (e2.s_mag == '0) begin
          for (int l = 0; l < 3; l++) begin
            if (e2.a_neg[l]) begin
              rv[l] = v3a_pkg::MIN_NEG;
            end else if (e2.a_mag[l] == '0) begin
              rv[l] = '0;
            end else begin
              rv[l] = v3a_pkg::MAX_POS;
            end
          end
          st = v3a_pkg::ST_DIV0;
        end else begin
          for (int l = 0; l < 3; l++) begin
            rv[l] = qs[l].v;
          end
          st = (qs[0].s | qs[1].s | qs[2].s) ? v3a_pkg::ST_SAT : v3a_pkg::ST_OK;
        end
      end
      v3a_pkg::OP_LEN: begin
        rsc = lq.v;
        st  = lq.s ? v3a_pkg::ST_SAT : v3a_pkg::ST_OK;
      end
      v3a_pkg::OP_NORM: begin
        if (len2 == '0) begin
          rv = '0;
          st = v3a_pkg::ST_OK;
        end else begin
          for (int l = 0; l < 3; l++) begin
            rv[l] = qs[l].v;
          end
          st = (qs[0].s | qs[1].s | qs[2].s) ? v3a_pkg::ST_SAT : v3a_pkg::ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d2_v[DVL-1];
    end
  end

  always_ff @(posedge clk) begin
    r_x      <= rv[0];
    r_y      <= rv[1];
    r_z      <= rv[2];
    r_scalar <= rsc;
    status   <= st;
  end

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == v3a_pkg::ST_OK || status == v3a_pkg::ST_SAT ||
              status == v3a_pkg::ST_DIV0))
    else $error("status code out of range");

  a_div0_scalar: assert property (@(posedge clk) disable iff (rst)
    (done && status == v3a_pkg::ST_DIV0) |-> r_scalar == '0)
    else $error("divide by zero result carries a scalar");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(v3a_pkg::LATENCY) done)
    else $error("result word missing at expected latency");

  a_reset_clears: assert property (@(posedge clk) rst |=> !done)
    else $error("done high after reset");

endmodule
